// ===== sv/wasm_module_section_parser_core_macros.svh =====
// Assertion macros for the module section parser
`ifndef WASM_MODULE_SECTION_PARSER_CORE_MACROS_SVH
`define WASM_MODULE_SECTION_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define WMSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WMSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WMSP_ASSERT(lbl, prop, msg)
`define WMSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/wmsp_pkg.sv =====
// Types, codes and helper functions for the module section parser
`timescale 1ns / 1ps
`default_nettype none
package wmsp_pkg;

  localparam int LEB_MAX_BYTES = 5;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [5:0] {
    PH_HDR, PH_SEC_ID, PH_SEC_LEN, PH_SKIP, PH_COUNT, PH_CNAME_LEN, PH_CNAME,
    PH_FT_HDR, PH_FT_PLEN, PH_FT_PARAMS, PH_FT_RLEN, PH_FT_RESULTS,
    PH_IM_MLEN, PH_IM_MOD, PH_IM_FLEN, PH_IM_FIELD, PH_IM_DESC, PH_IM_FUNC,
    PH_IM_GTYPE, PH_IM_GMUT, PH_FN_IDX, PH_TB_ELEM, PH_LM_FLAG, PH_LM_MIN,
    PH_LM_MAX
  } phase_t;

  localparam logic [3:0] REC_OK       = 4'd0;
  localparam logic [3:0] REC_SECTION  = 4'd1;
  localparam logic [3:0] REC_CUSTOM   = 4'd2;
  localparam logic [3:0] REC_FUNCTYPE = 4'd3;
  localparam logic [3:0] REC_IMPORT   = 4'd4;
  localparam logic [3:0] REC_FUNCIDX  = 4'd5;
  localparam logic [3:0] REC_TABLE    = 4'd6;
  localparam logic [3:0] REC_MEMORY   = 4'd7;
  localparam logic [3:0] REC_ERROR    = 4'd8;

  localparam logic [4:0] ERR_NONE        = 5'd0;
  localparam logic [4:0] ERR_TOO_SMALL   = 5'd1;
  localparam logic [4:0] ERR_PREAMBLE    = 5'd2;
  localparam logic [4:0] ERR_SEC_ID      = 5'd3;
  localparam logic [4:0] ERR_SEC_SIZE    = 5'd4;
  localparam logic [4:0] ERR_SEC_LEN     = 5'd5;
  localparam logic [4:0] ERR_TRUNCATED   = 5'd6;
  localparam logic [4:0] ERR_UNSUPPORTED = 5'd7;
  localparam logic [4:0] ERR_VEC_COUNT   = 5'd8;
  localparam logic [4:0] ERR_NAME        = 5'd9;
  localparam logic [4:0] ERR_FT_HDR      = 5'd10;
  localparam logic [4:0] ERR_VT_LIST     = 5'd11;
  localparam logic [4:0] ERR_VT          = 5'd12;
  localparam logic [4:0] ERR_FUNC_IDX    = 5'd13;
  localparam logic [4:0] ERR_LIMITS      = 5'd14;
  localparam logic [4:0] ERR_LIM_FLAG    = 5'd15;
  localparam logic [4:0] ERR_TABLE       = 5'd16;
  localparam logic [4:0] ERR_IM_DESC     = 5'd17;
  localparam logic [4:0] ERR_IM_GLOBAL   = 5'd18;

  localparam logic [3:0] SEC_CUSTOM = 4'd0;
  localparam logic [3:0] SEC_IMPORT = 4'd2;
  localparam logic [3:0] SEC_FUNC   = 4'd3;
  localparam logic [3:0] SEC_FUNCSIG = 4'd1;
  localparam logic [3:0] SEC_TABLE  = 4'd4;
  localparam logic [3:0] SEC_FIRST_UNSUPPORTED = 4'd6;
  localparam logic [7:0] SEC_ID_MAX = 8'd11;

  localparam logic [7:0] FUNCTYPE_TAG = 8'h60;
  localparam logic [7:0] FUNCREF_TAG  = 8'h70;
  localparam logic [7:0] VT_LOW       = 8'h7C;
  localparam logic [7:0] VT_HIGH      = 8'h7F;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  sec;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] oa;
    logic [31:0] ob;
    logic [31:0] lmin;
    logic [31:0] lmax;
    logic        hasmax;
    logic [1:0]  ikind;
    logic [31:0] desc;
    logic        mut;
  } rec_t;

  function automatic logic [7:0] preamble_byte(input logic [2:0] idx);
    case (idx)
      3'd1:    preamble_byte = 8'h61;
      3'd2:    preamble_byte = 8'h73;
      3'd3:    preamble_byte = 8'h6d;
      3'd4:    preamble_byte = 8'h01;
      default: preamble_byte = 8'h00;
    endcase
  endfunction

  function automatic phase_t entry_phase(input logic [3:0] sec);
    case (sec)
      4'd1:    entry_phase = PH_FT_HDR;
      4'd2:    entry_phase = PH_IM_MLEN;
      4'd3:    entry_phase = PH_FN_IDX;
      4'd4:    entry_phase = PH_TB_ELEM;
      default: entry_phase = PH_LM_FLAG;
    endcase
  endfunction

  function automatic logic [4:0] end_code(input phase_t ph);
    case (ph)
      PH_COUNT: end_code = ERR_VEC_COUNT;
      PH_CNAME_LEN, PH_CNAME, PH_IM_MLEN, PH_IM_MOD, PH_IM_FLEN, PH_IM_FIELD:
        end_code = ERR_NAME;
      PH_FT_HDR: end_code = ERR_FT_HDR;
      PH_FT_PLEN, PH_FT_PARAMS, PH_FT_RLEN, PH_FT_RESULTS: end_code = ERR_VT_LIST;
      PH_IM_FUNC, PH_FN_IDX: end_code = ERR_FUNC_IDX;
      PH_TB_ELEM: end_code = ERR_TABLE;
      PH_IM_DESC: end_code = ERR_IM_DESC;
      PH_IM_GTYPE, PH_IM_GMUT: end_code = ERR_IM_GLOBAL;
      default: end_code = ERR_LIMITS;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== sv/wmsp_byte_if.sv =====
// Handshake channel carrying module image bytes
`timescale 1ns / 1ps
`default_nettype none
interface wmsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  modport source (output valid, data_byte, is_last, input ready);
  modport sink (input valid, data_byte, is_last, output ready);
endinterface
`default_nettype wire

// ===== sv/wmsp_rec_if.sv =====
// Handshake channel carrying parser result records
`timescale 1ns / 1ps
`default_nettype none
interface wmsp_rec_if;
  logic        valid;
  logic        ready;
  logic [3:0]  record_kind;
  logic [3:0]  section_id;
  logic [31:0] value_a;
  logic [31:0] value_b;
  logic [31:0] offset_a;
  logic [31:0] offset_b;
  logic [31:0] limit_min;
  logic [31:0] limit_max;
  logic        has_max;
  logic [1:0]  import_kind;
  logic [31:0] desc_index;
  logic        is_mutable;
  modport source (output valid, record_kind, section_id, value_a, value_b, offset_a,
                  offset_b, limit_min, limit_max, has_max, import_kind, desc_index,
                  is_mutable, input ready);
  modport sink (input valid, record_kind, section_id, value_a, value_b, offset_a,
                offset_b, limit_min, limit_max, has_max, import_kind, desc_index,
                is_mutable, output ready);
endinterface
`default_nettype wire

// ===== sv/wasm_module_section_parser_core.sv =====
// WebAssembly module section parser, one byte per transaction
//
//   channel   dir   payload
//   bytes     in    data_byte, is_last
//   records   out   record kind, section id, values, offsets, limits, import fields
//
// One byte per cycle; each byte updates the parse state in the cycle it is taken.
// A byte yields up to two records, pushed into a 4-entry output queue; bytes are
// taken while the queue has two free slots, so the rate is set by record drain.
// rst is synchronous and returns the parser to the preamble check.
// After an error, bytes are consumed with no records until reset.
`timescale 1ns / 1ps
`default_nettype none
`include "wasm_module_section_parser_core_macros.svh"
module wasm_module_section_parser_core #(
  parameter int OFFSET_BITS = 32
) (
  input  wire  clk,
  input  wire  rst,
  wmsp_byte_if.sink   bytes,
  wmsp_rec_if.source  records
);
  import wmsp_pkg::*;

  localparam logic [31:0] OFS_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

  phase_t      phase, phase_n;
  logic [31:0] pos, pos_n;
  logic [3:0]  cur_sec, cur_sec_n;
  logic [31:0] sec_end, sec_end_n;
  logic [31:0] entries, entries_n;
  logic [31:0] list_left, list_left_n;
  logic [31:0] leb_acc, leb_acc_n;
  logic [2:0]  leb_cnt, leb_cnt_n;
  logic [31:0] h0_v, h0_v_n, h0_o, h0_o_n, h1_v, h1_v_n, h1_o, h1_o_n;
  logic [31:0] h2_min, h2_min_n, h3, h3_n;
  logic        h2_hm, h2_hm_n;
  logic [1:0]  h2_kind, h2_kind_n;
  logic        hdr_bad, hdr_bad_n;
  logic        failed, failed_n;

  rec_t        rec1, rec2;
  logic        rec1_v, rec2_v;

  rec_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              acc, pop;
  logic [1:0]        n_push;
  rec_t              slot0;

  assign bytes.ready = (count <= 3'(QDEPTH - 2));
  assign acc = bytes.valid && bytes.ready;
  assign pop = records.valid && records.ready;

  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic [31:0] after, left, v, ent_dec, maxv;
    logic        at_end, leb_use, done, too_long, next_ent, fire_import, fire_limits;
    logic        fire_types, fire_custom, mutv;
    logic [4:0]  sh;
    logic [2:0]  cnt_new;
    logic [31:0] acc_new;
    logic [4:0]  code;
    phase_t      ph;

    b = bytes.data_byte;
    last = bytes.is_last;
    ph = phase;
    after = pos + 32'd1;
    left = sec_end - after;
    at_end = (after == sec_end);
    sh = 5'(leb_cnt) * 5'd7;
    acc_new = leb_acc | ({25'd0, b[6:0]} << sh);
    cnt_new = leb_cnt + 3'd1;
    done = !b[7];
    too_long = b[7] && (cnt_new >= 3'(LEB_MAX_BYTES));
    v = acc_new;
    ent_dec = (entries != 32'd0) ? entries - 32'd1 : 32'd0;
    leb_use = 1'b0;
    next_ent = 1'b0;
    fire_import = 1'b0;
    fire_limits = 1'b0;
    fire_types = 1'b0;
    fire_custom = 1'b0;
    maxv = 32'd0;
    mutv = 1'b0;
    code = ERR_NONE;

    phase_n = phase;
    pos_n = pos;
    cur_sec_n = cur_sec;
    sec_end_n = sec_end;
    entries_n = entries;
    list_left_n = list_left;
    leb_acc_n = leb_acc;
    leb_cnt_n = leb_cnt;
    h0_v_n = h0_v; h0_o_n = h0_o; h1_v_n = h1_v; h1_o_n = h1_o;
    h2_min_n = h2_min; h2_hm_n = h2_hm; h2_kind_n = h2_kind; h3_n = h3;
    hdr_bad_n = hdr_bad;
    failed_n = failed;
    rec1 = '0;
    rec1_v = 1'b0;
    rec2 = '0;
    rec2_v = 1'b0;

    case (phase)
      PH_HDR: begin
        hdr_bad_n = hdr_bad | (b != preamble_byte(pos[2:0]));
        if (pos >= 32'd7) begin
          if (hdr_bad_n) code = ERR_PREAMBLE;
          else phase_n = PH_SEC_ID;
        end else if (last) begin
          code = ERR_TOO_SMALL;
        end
      end
      PH_SEC_ID: begin
        if (b > SEC_ID_MAX) code = ERR_SEC_ID;
        else begin
          cur_sec_n = b[3:0];
          leb_acc_n = 32'd0;
          leb_cnt_n = 3'd0;
          if (last) code = ERR_SEC_SIZE;
          else phase_n = PH_SEC_LEN;
        end
      end
      PH_SEC_LEN: begin
        leb_use = 1'b1;
        if (too_long || (!done && last)) code = ERR_SEC_LEN;
        else if (done) begin
          sec_end_n = after + v;
          rec1_v = 1'b1;
          rec1.kind = REC_SECTION;
          rec1.sec = cur_sec;
          rec1.va = v;
          rec1.oa = after & OFS_MASK;
          entries_n = 32'd0;
          if (last && v != 32'd0) code = ERR_TRUNCATED;
          else if (cur_sec >= SEC_FIRST_UNSUPPORTED) code = ERR_UNSUPPORTED;
          else begin
            phase_n = (cur_sec != SEC_CUSTOM) ? PH_COUNT : PH_CNAME_LEN;
            if (v == 32'd0) code = end_code(phase_n);
          end
        end
      end
      default: begin
        if (last && !at_end) code = ERR_TRUNCATED;
        else begin
          case (ph)
            PH_COUNT: begin
              leb_use = 1'b1;
              if (too_long) code = ERR_VEC_COUNT;
              else if (done) begin
                entries_n = v;
                phase_n = (v != 32'd0) ? entry_phase(cur_sec) : PH_SKIP;
              end
            end
            PH_CNAME_LEN: begin
              leb_use = 1'b1;
              if (too_long || (done && v > left)) code = ERR_NAME;
              else if (done) begin
                h0_v_n = v;
                h0_o_n = after;
                list_left_n = v;
                if (v == 32'd0) fire_custom = 1'b1;
                else phase_n = PH_CNAME;
              end
            end
            PH_CNAME: begin
              list_left_n = list_left - 32'd1;
              if (list_left_n == 32'd0) fire_custom = 1'b1;
            end
            PH_FT_HDR: begin
              if (b != FUNCTYPE_TAG) code = ERR_FT_HDR;
              else phase_n = PH_FT_PLEN;
            end
            PH_FT_PLEN, PH_FT_RLEN: begin
              leb_use = 1'b1;
              if (too_long || (done && v > left)) code = ERR_VT_LIST;
              else if (done) begin
                if (ph == PH_FT_PLEN) begin
                  h0_v_n = v; h0_o_n = after;
                end else begin
                  h1_v_n = v; h1_o_n = after;
                end
                list_left_n = v;
                if (v == 32'd0) fire_types = 1'b1;
                else phase_n = (ph == PH_FT_PLEN) ? PH_FT_PARAMS : PH_FT_RESULTS;
              end
            end
            PH_FT_PARAMS, PH_FT_RESULTS: begin
              if (!(b inside {[VT_LOW:VT_HIGH]})) code = ERR_VT;
              else begin
                list_left_n = list_left - 32'd1;
                if (list_left_n == 32'd0) fire_types = 1'b1;
              end
            end
            PH_IM_MLEN, PH_IM_FLEN: begin
              leb_use = 1'b1;
              if (too_long || (done && v > left)) code = ERR_NAME;
              else if (done) begin
                if (ph == PH_IM_MLEN) begin
                  h0_v_n = v; h0_o_n = after;
                end else begin
                  h1_v_n = v; h1_o_n = after;
                end
                list_left_n = v;
                if (v != 32'd0) phase_n = (ph == PH_IM_MLEN) ? PH_IM_MOD : PH_IM_FIELD;
                else phase_n = (ph == PH_IM_MLEN) ? PH_IM_FLEN : PH_IM_DESC;
              end
            end
            PH_IM_MOD, PH_IM_FIELD: begin
              list_left_n = list_left - 32'd1;
              if (list_left_n == 32'd0)
                phase_n = (ph == PH_IM_MOD) ? PH_IM_FLEN : PH_IM_DESC;
            end
            PH_IM_DESC: begin
              if (left == 32'd0 || b > 8'd3) code = ERR_IM_DESC;
              else begin
                h2_kind_n = b[1:0];
                h2_hm_n = 1'b0;
                h2_min_n = 32'd0;
                h3_n = 32'd0;
                case (b[1:0])
                  2'd0:    phase_n = PH_IM_FUNC;
                  2'd1:    phase_n = PH_TB_ELEM;
                  2'd2:    phase_n = PH_LM_FLAG;
                  default: phase_n = PH_IM_GTYPE;
                endcase
              end
            end
            PH_IM_FUNC, PH_IM_GTYPE: begin
              leb_use = 1'b1;
              if (too_long) code = (ph == PH_IM_FUNC) ? ERR_FUNC_IDX : ERR_IM_GLOBAL;
              else if (done) begin
                h3_n = v;
                if (ph == PH_IM_FUNC) fire_import = 1'b1;
                else phase_n = PH_IM_GMUT;
              end
            end
            PH_IM_GMUT: begin
              if (b > 8'd1) code = ERR_IM_GLOBAL;
              else begin
                mutv = b[0];
                fire_import = 1'b1;
              end
            end
            PH_FN_IDX: begin
              leb_use = 1'b1;
              if (too_long) code = ERR_FUNC_IDX;
              else if (done) begin
                rec1_v = 1'b1;
                rec1.kind = REC_FUNCIDX;
                rec1.sec = cur_sec;
                rec1.va = v;
                next_ent = 1'b1;
              end
            end
            PH_TB_ELEM: begin
              if (left < 32'd2 || b != FUNCREF_TAG) code = ERR_TABLE;
              else phase_n = PH_LM_FLAG;
            end
            PH_LM_FLAG: begin
              if (left < 32'd1) code = ERR_LIMITS;
              else if (b > 8'd1) code = ERR_LIM_FLAG;
              else begin
                h2_hm_n = b[0];
                h2_min_n = 32'd0;
                phase_n = PH_LM_MIN;
              end
            end
            PH_LM_MIN, PH_LM_MAX: begin
              leb_use = 1'b1;
              if (too_long) code = ERR_LIMITS;
              else if (done) begin
                if (ph == PH_LM_MAX) begin
                  maxv = v;
                  fire_limits = 1'b1;
                end else begin
                  h2_min_n = v;
                  if (h2_hm) phase_n = PH_LM_MAX;
                  else fire_limits = 1'b1;
                end
              end
            end
            default: ;
          endcase

          if (fire_limits) begin
            if (cur_sec == SEC_IMPORT) fire_import = 1'b1;
            else begin
              rec1_v = 1'b1;
              rec1.kind = (cur_sec == SEC_TABLE) ? REC_TABLE : REC_MEMORY;
              rec1.sec = cur_sec;
              rec1.lmin = h2_min_n;
              rec1.lmax = maxv;
              rec1.hasmax = h2_hm_n;
              next_ent = 1'b1;
            end
          end
          if (fire_import) begin
            rec1_v = 1'b1;
            rec1.kind = REC_IMPORT;
            rec1.sec = cur_sec;
            rec1.va = h0_v_n;
            rec1.oa = h0_o_n & OFS_MASK;
            rec1.vb = h1_v_n;
            rec1.ob = h1_o_n & OFS_MASK;
            rec1.lmin = h2_min_n;
            rec1.lmax = maxv;
            rec1.hasmax = h2_hm_n;
            rec1.ikind = h2_kind_n;
            rec1.desc = h3_n;
            rec1.mut = mutv;
            next_ent = 1'b1;
          end
          if (fire_types) begin
            if (ph == PH_FT_PLEN || ph == PH_FT_PARAMS) phase_n = PH_FT_RLEN;
            else begin
              rec1_v = 1'b1;
              rec1.kind = REC_FUNCTYPE;
              rec1.sec = cur_sec;
              rec1.va = h0_v_n;
              rec1.oa = h0_o_n & OFS_MASK;
              rec1.vb = h1_v_n;
              rec1.ob = h1_o_n & OFS_MASK;
              next_ent = 1'b1;
            end
          end
          if (fire_custom) begin
            rec1_v = 1'b1;
            rec1.kind = REC_CUSTOM;
            rec1.sec = cur_sec;
            rec1.va = h0_v_n;
            rec1.oa = h0_o_n & OFS_MASK;
            rec1.vb = sec_end - after;
            rec1.ob = after & OFS_MASK;
            phase_n = PH_SKIP;
          end
          if (next_ent) begin
            entries_n = ent_dec;
            phase_n = (ent_dec != 32'd0) ? entry_phase(cur_sec) : PH_SKIP;
          end
          if (code == ERR_NONE && at_end) begin
            if (phase_n != PH_SKIP) code = end_code(phase_n);
            else phase_n = PH_SEC_ID;
          end
        end
      end
    endcase

    if (leb_use) begin
      leb_acc_n = done ? 32'd0 : acc_new;
      leb_cnt_n = done ? 3'd0 : cnt_new;
    end

    pos_n = after;
    if (code == ERR_NONE && last && phase_n != PH_SEC_ID) code = ERR_TRUNCATED;

    if (code != ERR_NONE) begin
      rec2_v = 1'b1;
      rec2.kind = REC_ERROR;
      rec2.sec = (code <= ERR_SEC_ID) ? 4'd0 : cur_sec_n;
      rec2.va = {27'd0, code};
      rec2.oa = pos & OFS_MASK;
      failed_n = 1'b1;
    end else if (last) begin
      rec2_v = 1'b1;
      rec2.kind = REC_OK;
      phase_n = PH_HDR;
      pos_n = 32'd0;
      cur_sec_n = 4'd0;
      sec_end_n = 32'd0;
      entries_n = 32'd0;
      list_left_n = 32'd0;
      leb_acc_n = 32'd0;
      leb_cnt_n = 3'd0;
      h0_v_n = 32'd0; h0_o_n = 32'd0; h1_v_n = 32'd0; h1_o_n = 32'd0;
      h2_min_n = 32'd0; h2_hm_n = 1'b0; h2_kind_n = 2'd0; h3_n = 32'd0;
      hdr_bad_n = 1'b0;
    end

    if (failed) begin
      rec1_v = 1'b0;
      rec2_v = 1'b0;
    end
  end

  always_comb begin
    n_push = 2'(rec1_v) + 2'(rec2_v);
    slot0 = rec1_v ? rec1 : rec2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR;
      pos <= 32'd0;
      cur_sec <= 4'd0;
      sec_end <= 32'd0;
      entries <= 32'd0;
      list_left <= 32'd0;
      leb_acc <= 32'd0;
      leb_cnt <= 3'd0;
      h0_v <= 32'd0; h0_o <= 32'd0; h1_v <= 32'd0; h1_o <= 32'd0;
      h2_min <= 32'd0; h2_hm <= 1'b0; h2_kind <= 2'd0; h3 <= 32'd0;
      hdr_bad <= 1'b0;
      failed <= 1'b0;
    end else if (acc && !failed) begin
      phase <= phase_n;
      pos <= pos_n;
      cur_sec <= cur_sec_n;
      sec_end <= sec_end_n;
      entries <= entries_n;
      list_left <= list_left_n;
      leb_acc <= leb_acc_n;
      leb_cnt <= leb_cnt_n;
      h0_v <= h0_v_n; h0_o <= h0_o_n; h1_v <= h1_v_n; h1_o <= h1_o_n;
      h2_min <= h2_min_n; h2_hm <= h2_hm_n; h2_kind <= h2_kind_n; h3 <= h3_n;
      hdr_bad <= hdr_bad_n;
      failed <= failed_n;
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (acc && n_push != 2'd0) q[wr_ptr] <= slot0;
    if (acc && n_push == 2'd2) q[wr_ptr + QPTR_W'(1)] <= rec2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (acc) wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + (acc ? (QPTR_W + 1)'(n_push) : '0) - (QPTR_W + 1)'(pop);
    end
  end

  always_comb begin
    records.valid       = (count != '0);
    records.record_kind = q[rd_ptr].kind;
    records.section_id  = q[rd_ptr].sec;
    records.value_a     = q[rd_ptr].va;
    records.value_b     = q[rd_ptr].vb;
    records.offset_a    = q[rd_ptr].oa;
    records.offset_b    = q[rd_ptr].ob;
    records.limit_min   = q[rd_ptr].lmin;
    records.limit_max   = q[rd_ptr].lmax;
    records.has_max     = q[rd_ptr].hasmax;
    records.import_kind = q[rd_ptr].ikind;
    records.desc_index  = q[rd_ptr].desc;
    records.is_mutable  = q[rd_ptr].mut;
  end

  `WMSP_ASSERT(a_count_bound, count <= (QPTR_W + 1)'(QDEPTH), "output queue overflow")
  `WMSP_ASSERT(a_failed_sticky, failed |=> failed, "error state left without reset")
  `WMSP_ASSERT(a_no_push_failed, (acc && failed) |=> count <= $past(count), "record after error")
  `WMSP_ASSERT_ALWAYS(a_reset_empty, rst |=> count == '0, "queue not empty after reset")

endmodule
`default_nettype wire

// ===== tb/wasm_module_section_parser_core_tb.sv =====
// Self-checking testbench for the WebAssembly module section parser core
`timescale 1ns / 1ps
module wasm_module_section_parser_core_tb;
  import wmsp_pkg::*;

  typedef logic [7:0] u8_q[$];

  logic clk;
  logic rst;
  wmsp_byte_if bytes_if();
  wmsp_rec_if records_if();

  wasm_module_section_parser_core DUT (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_if),
    .records(records_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // parser state mirrored by the predictor
  phase_t      ph;
  logic [31:0] pos, sec_end, ents, lst, acc;
  logic [3:0]  cur;
  int          lcnt;
  logic [63:0] held[4];
  bit          failed;

  rec_t expected_records[$];
  int   mismatches, records_checked, bytes_sent, modules_sent, cycles;
  bit   steady;
  bit   first_send;

  localparam logic [7:0] MAGIC[8] = '{8'h00, 8'h61, 8'h73, 8'h6d, 8'h01, 8'h00, 8'h00, 8'h00};
  localparam int CYCLE_LIMIT = 200000;

  task automatic clear_parse_state();
    ph = PH_HDR;
    pos = 0;
    sec_end = 0;
    ents = 0;
    lst = 0;
    acc = 0;
    cur = 0;
    lcnt = 0;
    for (int i = 0; i < 4; i++) held[i] = 0;
    failed = 0;
  endtask

  function automatic int leb_take(input logic [7:0] b, output logic [31:0] val);
    logic [63:0] w;
    w = 64'(b[6:0]) << (7 * lcnt);
    acc |= w[31:0];
    lcnt++;
    val = 0;
    if (!b[7]) begin
      val = acc;
      acc = 0;
      lcnt = 0;
      return 1;
    end
    if (lcnt >= LEB_MAX_BYTES) return 2;
    return 0;
  endfunction

  function automatic phase_t first_entry_phase(input logic [3:0] sec);
    case (sec)
      SEC_FUNCSIG: return PH_FT_HDR;
      SEC_IMPORT: return PH_IM_MLEN;
      SEC_FUNC:   return PH_FN_IDX;
      SEC_TABLE:  return PH_TB_ELEM;
      default:    return PH_LM_FLAG;
    endcase
  endfunction

  function automatic logic [4:0] short_section_code(input phase_t p);
    case (p)
      PH_COUNT: return ERR_VEC_COUNT;
      PH_CNAME_LEN, PH_CNAME, PH_IM_MLEN, PH_IM_MOD, PH_IM_FLEN, PH_IM_FIELD: return ERR_NAME;
      PH_FT_HDR: return ERR_FT_HDR;
      PH_FT_PLEN, PH_FT_PARAMS, PH_FT_RLEN, PH_FT_RESULTS: return ERR_VT_LIST;
      PH_IM_FUNC, PH_FN_IDX: return ERR_FUNC_IDX;
      PH_TB_ELEM: return ERR_TABLE;
      PH_IM_DESC: return ERR_IM_DESC;
      PH_IM_GTYPE, PH_IM_GMUT: return ERR_IM_GLOBAL;
      default: return ERR_LIMITS;
    endcase
  endfunction

  task automatic push_record(input rec_t r);
    expected_records.push_back(r);
  endtask

  task automatic advance_entry();
    if (ents != 0) ents--;
    ph = (ents != 0) ? first_entry_phase(cur) : PH_SKIP;
  endtask

  task automatic emit_import(input logic [31:0] maxv, input logic mutv);
    rec_t r;
    r = '0;
    r.kind = REC_IMPORT;
    r.sec = cur;
    r.va = held[0][63:32];
    r.oa = held[0][31:0];
    r.vb = held[1][63:32];
    r.ob = held[1][31:0];
    r.lmin = held[2][31:0];
    r.lmax = maxv;
    r.hasmax = held[2][32];
    r.ikind = held[2][34:33];
    r.desc = held[3][31:0];
    r.mut = mutv;
    push_record(r);
    advance_entry();
  endtask

  task automatic emit_limits(input logic [31:0] maxv);
    rec_t r;
    if (cur == SEC_IMPORT) begin
      emit_import(maxv, 1'b0);
    end else begin
      r = '0;
      r.kind = (cur == SEC_TABLE) ? REC_TABLE : REC_MEMORY;
      r.sec = cur;
      r.lmin = held[2][31:0];
      r.lmax = maxv;
      r.hasmax = held[2][32];
      push_record(r);
      advance_entry();
    end
  endtask

  task automatic emit_type_list();
    rec_t r;
    if (ph == PH_FT_PLEN || ph == PH_FT_PARAMS) begin
      ph = PH_FT_RLEN;
    end else begin
      r = '0;
      r.kind = REC_FUNCTYPE;
      r.sec = cur;
      r.va = held[0][63:32];
      r.oa = held[0][31:0];
      r.vb = held[1][63:32];
      r.ob = held[1][31:0];
      push_record(r);
      advance_entry();
    end
  endtask

  task automatic emit_custom(input logic [31:0] data_at);
    rec_t r;
    r = '0;
    r.kind = REC_CUSTOM;
    r.sec = cur;
    r.va = held[0][63:32];
    r.oa = held[0][31:0];
    r.vb = sec_end - data_at;
    r.ob = data_at;
    push_record(r);
    ph = PH_SKIP;
  endtask

  task automatic parse_payload(input logic [7:0] b, output logic [4:0] code);
    logic [31:0] after, left, v;
    phase_t p;
    int k;
    after = pos + 1;
    left = sec_end - after;
    p = ph;
    code = ERR_NONE;
    v = 0;
    case (p)
      PH_COUNT: begin
        k = leb_take(b, v);
        if (k == 2) code = ERR_VEC_COUNT;
        else if (k == 1) begin
          ents = v;
          ph = (v != 0) ? first_entry_phase(cur) : PH_SKIP;
        end
      end
      PH_CNAME_LEN: begin
        k = leb_take(b, v);
        if (k == 2 || (k == 1 && v > left)) code = ERR_NAME;
        else if (k == 1) begin
          held[0] = {v, after};
          lst = v;
          if (v == 0) emit_custom(after);
          else ph = PH_CNAME;
        end
      end
      PH_CNAME: begin
        lst--;
        if (lst == 0) emit_custom(after);
      end
      PH_FT_HDR: begin
        if (b != FUNCTYPE_TAG) code = ERR_FT_HDR;
        else ph = PH_FT_PLEN;
      end
      PH_FT_PLEN, PH_FT_RLEN: begin
        k = leb_take(b, v);
        if (k == 2 || (k == 1 && v > left)) code = ERR_VT_LIST;
        else if (k == 1) begin
          if (p == PH_FT_PLEN) held[0] = {v, after};
          else held[1] = {v, after};
          lst = v;
          if (v == 0) emit_type_list();
          else ph = (p == PH_FT_PLEN) ? PH_FT_PARAMS : PH_FT_RESULTS;
        end
      end
      PH_FT_PARAMS, PH_FT_RESULTS: begin
        if (b < VT_LOW || b > VT_HIGH) code = ERR_VT;
        else begin
          lst--;
          if (lst == 0) emit_type_list();
        end
      end
      PH_IM_MLEN, PH_IM_FLEN: begin
        k = leb_take(b, v);
        if (k == 2 || (k == 1 && v > left)) code = ERR_NAME;
        else if (k == 1) begin
          if (p == PH_IM_MLEN) held[0] = {v, after};
          else held[1] = {v, after};
          lst = v;
          if (v != 0) ph = (p == PH_IM_MLEN) ? PH_IM_MOD : PH_IM_FIELD;
          else ph = (p == PH_IM_MLEN) ? PH_IM_FLEN : PH_IM_DESC;
        end
      end
      PH_IM_MOD, PH_IM_FIELD: begin
        lst--;
        if (lst == 0) ph = (p == PH_IM_MOD) ? PH_IM_FLEN : PH_IM_DESC;
      end
      PH_IM_DESC: begin
        if (left == 0 || b > 8'd3) code = ERR_IM_DESC;
        else begin
          held[2] = 64'(b) << 33;
          held[3] = 0;
          case (b[1:0])
            2'd0: ph = PH_IM_FUNC;
            2'd1: ph = PH_TB_ELEM;
            2'd2: ph = PH_LM_FLAG;
            default: ph = PH_IM_GTYPE;
          endcase
        end
      end
      PH_IM_FUNC, PH_IM_GTYPE: begin
        k = leb_take(b, v);
        if (k == 2) code = (p == PH_IM_FUNC) ? ERR_FUNC_IDX : ERR_IM_GLOBAL;
        else if (k == 1) begin
          held[3] = 64'(v);
          if (p == PH_IM_FUNC) emit_import(32'd0, 1'b0);
          else ph = PH_IM_GMUT;
        end
      end
      PH_IM_GMUT: begin
        if (b > 8'd1) code = ERR_IM_GLOBAL;
        else emit_import(32'd0, b[0]);
      end
      PH_FN_IDX: begin
        k = leb_take(b, v);
        if (k == 2) code = ERR_FUNC_IDX;
        else if (k == 1) begin
          rec_t r;
          r = '0;
          r.kind = REC_FUNCIDX;
          r.sec = cur;
          r.va = v;
          push_record(r);
          advance_entry();
        end
      end
      PH_TB_ELEM: begin
        if (left < 2 || b != FUNCREF_TAG) code = ERR_TABLE;
        else ph = PH_LM_FLAG;
      end
      PH_LM_FLAG: begin
        if (left < 1) code = ERR_LIMITS;
        else if (b > 8'd1) code = ERR_LIM_FLAG;
        else begin
          held[2] = (held[2] & (64'd3 << 33)) | (64'(b) << 32);
          ph = PH_LM_MIN;
        end
      end
      PH_LM_MIN, PH_LM_MAX: begin
        k = leb_take(b, v);
        if (k == 2) code = ERR_LIMITS;
        else if (k == 1) begin
          if (p == PH_LM_MAX) emit_limits(v);
          else begin
            held[2] |= 64'(v);
            if (held[2][32]) ph = PH_LM_MAX;
            else emit_limits(32'd0);
          end
        end
      end
      default: ;
    endcase
  endtask

  // expected records for one accepted byte
  task automatic predict_byte(input logic [7:0] b, input bit last);
    logic [31:0] here, v;
    logic [4:0] code;
    int k;
    rec_t r;
    if (failed) return;
    here = pos;
    code = ERR_NONE;
    v = 0;
    case (ph)
      PH_HDR: begin
        if (b != MAGIC[here[2:0]]) held[0] = 1;
        if (here >= 7) begin
          if (held[0] != 0) code = ERR_PREAMBLE;
          else ph = PH_SEC_ID;
        end else if (last) begin
          code = ERR_TOO_SMALL;
        end
      end
      PH_SEC_ID: begin
        if (b > SEC_ID_MAX) code = ERR_SEC_ID;
        else begin
          cur = b[3:0];
          acc = 0;
          lcnt = 0;
          if (last) code = ERR_SEC_SIZE;
          else ph = PH_SEC_LEN;
        end
      end
      PH_SEC_LEN: begin
        k = leb_take(b, v);
        if (k == 2 || (k == 0 && last)) code = ERR_SEC_LEN;
        else if (k == 1) begin
          sec_end = here + 1 + v;
          r = '0;
          r.kind = REC_SECTION;
          r.sec = cur;
          r.va = v;
          r.oa = here + 1;
          push_record(r);
          ents = 0;
          if (last && v != 0) code = ERR_TRUNCATED;
          else if (cur >= SEC_FIRST_UNSUPPORTED) code = ERR_UNSUPPORTED;
          else begin
            ph = (cur != SEC_CUSTOM) ? PH_COUNT : PH_CNAME_LEN;
            if (v == 0) code = short_section_code(ph);
          end
        end
      end
      default: begin
        if (last && here + 1 != sec_end) code = ERR_TRUNCATED;
        else begin
          parse_payload(b, code);
          if (code == ERR_NONE && here + 1 == sec_end) begin
            if (ph != PH_SKIP) code = short_section_code(ph);
            else ph = PH_SEC_ID;
          end
        end
      end
    endcase
    pos = here + 1;
    if (code == ERR_NONE && last && ph != PH_SEC_ID) code = ERR_TRUNCATED;
    if (code != ERR_NONE) begin
      r = '0;
      r.kind = REC_ERROR;
      r.sec = (code <= ERR_SEC_ID) ? 4'd0 : cur;
      r.va = 32'(code);
      r.oa = here;
      push_record(r);
      failed = 1;
    end else if (last) begin
      r = '0;
      r.kind = REC_OK;
      push_record(r);
      clear_parse_state();
    end
  endtask

  // record checker
  function automatic bit field_ok(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e === a) return 1;
    if (mismatches < 10) $display("  field %s: expected %0h, got %0h", nm, e, a);
    return 0;
  endfunction

  always @(posedge clk) begin
    rec_t e;
    bit ok;
    if (!rst && records_if.valid && records_if.ready) begin
      records_checked++;
      if (expected_records.size() == 0) begin
        if (mismatches < 10) $display("Unexpected record kind %0d at cycle %0d",
                                      records_if.record_kind, cycles);
        mismatches++;
      end else begin
        e = expected_records.pop_front();
        ok = 1;
        ok &= field_ok("record_kind", 32'(e.kind), 32'(records_if.record_kind));
        ok &= field_ok("section_id", 32'(e.sec), 32'(records_if.section_id));
        ok &= field_ok("value_a", e.va, records_if.value_a);
        ok &= field_ok("value_b", e.vb, records_if.value_b);
        ok &= field_ok("offset_a", e.oa, records_if.offset_a);
        ok &= field_ok("offset_b", e.ob, records_if.offset_b);
        ok &= field_ok("limit_min", e.lmin, records_if.limit_min);
        ok &= field_ok("limit_max", e.lmax, records_if.limit_max);
        ok &= field_ok("has_max", 32'(e.hasmax), 32'(records_if.has_max));
        ok &= field_ok("import_kind", 32'(e.ikind), 32'(records_if.import_kind));
        ok &= field_ok("desc_index", e.desc, records_if.desc_index);
        ok &= field_ok("is_mutable", 32'(e.mut), 32'(records_if.is_mutable));
        if (!ok) begin
          if (mismatches < 10) $display("Mismatch in record %0d (kind %0d) at cycle %0d",
                                        records_checked, e.kind, cycles);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    records_if.ready <= steady || ($urandom_range(99) >= 17);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // byte sender
  task automatic send_byte(input logic [7:0] b, input bit last);
    if (!first_send && !steady && $urandom_range(99) < 17) begin
      bytes_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    first_send = 0;
    bytes_if.valid <= 1'b1;
    bytes_if.data_byte <= b;
    bytes_if.is_last <= last;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_image(input u8_q img);
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
    modules_sent++;
  endtask

  task automatic wait_drained();
    bytes_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  // image builders
  task automatic push_leb(ref u8_q q, input logic [31:0] v, input int width);
    int n;
    logic [7:0] b;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    if (width > n) n = width;
    for (int i = 0; i < n; i++) begin
      b = 8'((v >> (7 * i)) & 32'h7F);
      if (i < n - 1) b[7] = 1'b1;
      q.push_back(b);
    end
  endtask

  // five bytes whose top bits fall beyond 32 and are dropped
  task automatic push_leb_wide(ref u8_q q, input logic [31:0] v);
    for (int i = 0; i < 4; i++) q.push_back({1'b1, v[7*i +: 7]});
    q.push_back({1'b0, 3'($urandom_range(1, 7)), v[31:28]});
  endtask

  function automatic int leb_pad();
    return ($urandom_range(9) == 0) ? 5 : 0;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(0, 127);
      1: return $urandom_range(0, 20000);
      2: return $urandom;
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  task automatic add_section(ref u8_q img, input logic [3:0] id, input u8_q body);
    img.push_back(8'(id));
    push_leb(img, body.size(), leb_pad());
    img = {img, body};
  endtask

  task automatic push_name(ref u8_q q);
    int n;
    n = $urandom_range(0, 3);
    push_leb(q, n, leb_pad());
    repeat (n) q.push_back(8'($urandom));
  endtask

  task automatic push_limits(ref u8_q q);
    bit hm;
    hm = $urandom_range(1);
    q.push_back(8'(hm));
    if ($urandom_range(7) == 0) push_leb_wide(q, pick_value());
    else push_leb(q, pick_value(), leb_pad());
    if (hm) push_leb(q, pick_value(), leb_pad());
  endtask

  task automatic random_section(ref u8_q img);
    u8_q body;
    logic [3:0] id;
    int cnt, n, kd;
    id = 4'($urandom_range(0, 5));
    cnt = $urandom_range(1, 3);
    if (id == SEC_CUSTOM) begin
      push_name(body);
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
    end else begin
      if (id >= SEC_TABLE) cnt = 1;
      push_leb(body, cnt, leb_pad());
      repeat (cnt) begin
        case (id)
          SEC_FUNCSIG: begin
            body.push_back(FUNCTYPE_TAG);
            repeat (2) begin
              n = $urandom_range(0, 3);
              push_leb(body, n, leb_pad());
              repeat (n) body.push_back(8'($urandom_range(VT_LOW, VT_HIGH)));
            end
          end
          SEC_IMPORT: begin
            push_name(body);
            push_name(body);
            kd = $urandom_range(3);
            body.push_back(8'(kd));
            case (kd)
              0: push_leb(body, pick_value(), leb_pad());
              1: begin
                body.push_back(FUNCREF_TAG);
                push_limits(body);
              end
              2: push_limits(body);
              default: begin
                push_leb(body, pick_value(), leb_pad());
                body.push_back(8'($urandom_range(1)));
              end
            endcase
          end
          SEC_FUNC: push_leb(body, pick_value(), leb_pad());
          SEC_TABLE: begin
            body.push_back(FUNCREF_TAG);
            push_limits(body);
          end
          default: push_limits(body);
        endcase
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
    end
    add_section(img, id, body);
  endtask

  task automatic random_module(output u8_q img);
    img = {};
    foreach (MAGIC[i]) img.push_back(MAGIC[i]);
    repeat ($urandom_range(0, 3)) random_section(img);
  endtask

  // tests
  task automatic test_preamble_only();
    u8_q img;
    foreach (MAGIC[i]) img.push_back(MAGIC[i]);
    send_image(img);
  endtask

  task automatic test_custom_and_type();
    u8_q img, body;
    foreach (MAGIC[i]) img.push_back(MAGIC[i]);
    push_leb(body, 0, 5);
    body = {body, 8'hFF, 8'h80};
    add_section(img, SEC_CUSTOM, body);
    body = {8'h02, 8'h61, 8'h62};
    add_section(img, SEC_CUSTOM, body);
    body = {8'h02, 8'h60, 8'h00, 8'h00,
            8'h60, 8'h04, 8'h7C, 8'h7D, 8'h7E, 8'h7F, 8'h01, 8'h7F};
    add_section(img, SEC_FUNCSIG, body);
    send_image(img);
  endtask

  task automatic test_import_kinds();
    u8_q img, body;
    foreach (MAGIC[i]) img.push_back(MAGIC[i]);
    body = {8'h04,
            8'h01, 8'h6D, 8'h01, 8'h66, 8'h00, 8'h05,
            8'h00, 8'h00, 8'h01, FUNCREF_TAG, 8'h01, 8'h00, 8'h7F,
            8'h01, 8'hAA, 8'h00, 8'h02, 8'h00, 8'h10,
            8'h00, 8'h01, 8'h55, 8'h03, 8'h7F, 8'h01};
    add_section(img, SEC_IMPORT, body);
    send_image(img);
  endtask

  task automatic test_function_indices();
    u8_q img, body;
    foreach (MAGIC[i]) img.push_back(MAGIC[i]);
    body = {8'h03, 8'h00};
    push_leb(body, 32'hFFFFFFFF, 5);
    push_leb_wide(body, 32'h12345678);
    body = {body, 8'hEE, 8'h00};
    add_section(img, SEC_FUNC, body);
    send_image(img);
  endtask

  task automatic test_table_and_memory();
    u8_q img, body;
    foreach (MAGIC[i]) img.push_back(MAGIC[i]);
    body = {8'h01, FUNCREF_TAG, 8'h01, 8'h00};
    push_leb(body, 32'hFFFFFFFF, 0);
    add_section(img, SEC_TABLE, body);
    body = {8'h01, 8'h00, 8'h7F};
    add_section(img, 4'd5, body);
    send_image(img);
  endtask

  task automatic test_random_modules();
    u8_q img;
    int m;
    m = 0;
    while (bytes_sent < 220 || m < 5) begin
      random_module(img);
      steady = (m == 2) || (m == 3);
      send_image(img);
      if (m == 4) wait_drained();
      m++;
    end
    steady = 0;
  endtask

  // a single randomly corrupted or truncated module, then more bytes; after an error the block stays silent until reset
  task automatic test_error_module();
    u8_q img;
    int at;
    random_module(img);
    case ($urandom_range(4))
      0: img[$urandom_range(0, img.size() - 1)] ^= 8'(1 << $urandom_range(7));
      1: img[$urandom_range(0, img.size() - 1)] = 8'($urandom);
      2: begin
        at = $urandom_range(0, img.size() - 1);
        img = img[0:at];
      end
      3: img = {img, 8'($urandom_range(6, 255)), 8'h01, 8'h00};
      default: img = {img, 8'h03, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
    endcase
    send_image(img);
    repeat (6) send_byte(8'($urandom), $urandom_range(1));
  endtask

  initial begin
    rst <= 1'b1;
    bytes_if.valid <= 1'b0;
    bytes_if.data_byte <= '0;
    bytes_if.is_last <= 1'b0;
    mismatches = 0;
    records_checked = 0;
    bytes_sent = 0;
    modules_sent = 0;
    steady = 0;
    first_send = 1;
    clear_parse_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_preamble_only();
    test_custom_and_type();
    test_import_kinds();
    test_function_indices();
    test_table_and_memory();
    test_random_modules();
    test_error_module();

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_records.size() != 0) mismatches++;
    $display("Sent %0d bytes in %0d module images, checked %0d records.",
             bytes_sent, modules_sent, records_checked);
    $display("Covered every section kind, import kind, limits form and a final error case.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
